/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [3:0] error_code;
        logic       last;
    } t_out_item;

    // One classified input: up to four data bytes, or a done or error marker.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_data;
        logic            done;
        logic [3:0]      err;
    } t_job;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BODY,
        M_ESC,
        M_HEX1,
        M_WANT_BS,
        M_WANT_U,
        M_HEX2,
        M_TAIL
    } t_mode;

    localparam logic [3:0] ERR_OK           = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_ESCAPE       = 4'd3;
    localparam logic [3:0] ERR_HEX          = 4'd4;
    localparam logic [3:0] ERR_UNPAIRED_HI  = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
    localparam logic [3:0] ERR_UNPAIRED_LO  = 4'd7;
    localparam logic [3:0] ERR_LEAD         = 4'd8;
    localparam logic [3:0] ERR_CONT         = 4'd9;
    localparam logic [3:0] ERR_SCALAR       = 4'd10;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd11;

    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [15:0] SURR_HI_LO = 16'hD800;
    localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
    localparam logic [15:0] SURR_LO_LO = 16'hDC00;
    localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

endpackage

/* rtl/jsu_front.sv */
// Front end: runs the string parser one byte per cycle while i_take is high and emits jobs.
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output logic     o_job_push,
    output t_job     o_job
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_hex_accum, n_hex_accum;
    logic [9:0]  r_high, n_high;
    logic [1:0]  r_tail, n_tail;
    logic [20:0] r_scalar, n_scalar;
    logic [1:0]  r_min, n_min;
    logic [7:0]  r_held [3];

    logic        held_we;
    logic [1:0]  held_idx;

    logic [7:0]  b;
    logic [4:0]  hex_dig;   // bit 4 set when not a hex digit
    logic [15:0] hex_next;
    logic [20:0] scalar_next;
    logic [20:0] pt;
    logic [20:0] lo_bound;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]  enc_last;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    assign b           = i_item.data_byte;
    assign hex_dig     = hex_val(b);
    assign hex_next    = {r_hex_accum[11:0], hex_dig[3:0]};
    assign scalar_next = {r_scalar[14:0], b[5:0]};

    // Scalar to encode: a surrogate pair in the second escape, the plain value otherwise.
    assign pt = (r_mode == M_HEX2) ? (SUPP_BASE + {1'b0, r_high, hex_next[9:0]})
                                   : {5'd0, hex_next};

    always_comb begin
        enc_bytes = '0;
        if (pt <= 21'h7F) begin
            enc_bytes[0] = pt[7:0];
            enc_last     = 2'd0;
        end else if (pt <= 21'h7FF) begin
            enc_bytes[0] = {3'b110, pt[10:6]};
            enc_bytes[1] = {2'b10, pt[5:0]};
            enc_last     = 2'd1;
        end else if (pt <= 21'hFFFF) begin
            enc_bytes[0] = {4'b1110, pt[15:12]};
            enc_bytes[1] = {2'b10, pt[11:6]};
            enc_bytes[2] = {2'b10, pt[5:0]};
            enc_last     = 2'd2;
        end else begin
            enc_bytes[0] = {5'b11110, pt[20:18]};
            enc_bytes[1] = {2'b10, pt[17:12]};
            enc_bytes[2] = {2'b10, pt[11:6]};
            enc_bytes[3] = {2'b10, pt[5:0]};
            enc_last     = 2'd3;
        end
    end

    always_comb begin
        unique case (r_min)
            2'd1:    lo_bound = 21'h80;
            2'd2:    lo_bound = 21'h800;
            default: lo_bound = SUPP_BASE;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_hex_count = r_hex_count;
        n_hex_accum = r_hex_accum;
        n_high      = r_high;
        n_tail      = r_tail;
        n_scalar    = r_scalar;
        n_min       = r_min;
        held_we     = 1'b0;
        held_idx    = 2'd0;
        o_job_push  = 1'b0;
        o_job       = '0;

        if (i_item.end_of_data) begin
            o_job_push = 1'b1;
            o_job.err  = (r_mode == M_IDLE) ? ERR_NO_QUOTE : ERR_UNTERMINATED;
            n_mode     = M_IDLE;
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                    if (b == CH_QUOTE) begin
                        n_mode = M_BODY;
                    end else begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_NO_QUOTE;
                    end
                end
                M_BODY: begin
                    priority if (b == CH_QUOTE) begin
                        o_job_push = 1'b1;
                        o_job.done = 1'b1;
                        n_mode     = M_IDLE;
                    end else if (b < 8'h20) begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_CONTROL;
                        n_mode     = M_IDLE;
                    end else if (b == CH_BSL) begin
                        n_mode = M_ESC;
                    end else if (b < 8'h80) begin
                        o_job_push     = 1'b1;
                        o_job.is_data  = 1'b1;
                        o_job.bytes[0] = b;
                    end else if (b >= 8'hC2 && b <= 8'hF4) begin
                        // Hold the lead byte until the sequence checks out.
                        held_we  = 1'b1;
                        held_idx = 2'd0;
                        n_mode   = M_TAIL;
                        if (b <= 8'hDF) begin
                            n_min    = 2'd1;
                            n_scalar = {16'd0, b[4:0]};
                        end else if (b <= 8'hEF) begin
                            n_min    = 2'd2;
                            n_scalar = {17'd0, b[3:0]};
                        end else begin
                            n_min    = 2'd3;
                            n_scalar = {18'd0, b[2:0]};
                        end
                        n_tail = n_min;
                    end else begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_LEAD;
                        n_mode     = M_IDLE;
                    end
                end
                M_TAIL: begin
                    if (b[7:6] != 2'b10) begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_CONT;
                        n_mode     = M_IDLE;
                    end else begin
                        n_scalar = scalar_next;
                        if (r_tail > 2'd1) begin
                            held_we  = 1'b1;
                            held_idx = 2'(r_min - r_tail + 2'd1);
                            n_tail   = 2'(r_tail - 2'd1);
                        end else begin
                            n_tail = 2'd0;
                            if (scalar_next < lo_bound || scalar_next > MAX_SCALAR ||
                                (scalar_next >= {5'd0, SURR_HI_LO} &&
                                 scalar_next <= {5'd0, SURR_LO_HI})) begin
                                o_job_push = 1'b1;
                                o_job.err  = ERR_SCALAR;
                                n_mode     = M_IDLE;
                            end else begin
                                o_job_push     = 1'b1;
                                o_job.is_data  = 1'b1;
                                o_job.last_idx = r_min;
                                o_job.bytes[0] = r_held[0];
                                o_job.bytes[1] = (r_min == 2'd1) ? b : r_held[1];
                                o_job.bytes[2] = (r_min == 2'd2) ? b : r_held[2];
                                o_job.bytes[3] = b;
                                n_mode         = M_BODY;
                            end
                        end
                    end
                end
                M_ESC: begin
                    o_job.is_data = 1'b1;
                    o_job_push    = 1'b1;
                    n_mode        = M_BODY;
                    unique case (b)
                        8'h22, 8'h5C, 8'h2F: o_job.bytes[0] = b;
                        8'h62:               o_job.bytes[0] = 8'h08;
                        8'h66:               o_job.bytes[0] = 8'h0C;
                        8'h6E:               o_job.bytes[0] = 8'h0A;
                        8'h72:               o_job.bytes[0] = 8'h0D;
                        8'h74:               o_job.bytes[0] = 8'h09;
                        CH_U: begin
                            o_job_push  = 1'b0;
                            n_mode      = M_HEX1;
                            n_hex_count = 2'd0;
                            n_hex_accum = 16'd0;
                        end
                        default: begin
                            o_job.is_data = 1'b0;
                            o_job.err     = ERR_ESCAPE;
                            n_mode        = M_IDLE;
                        end
                    endcase
                end
                M_HEX1, M_HEX2: begin
                    if (hex_dig[4]) begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_HEX;
                        n_mode     = M_IDLE;
                    end else begin
                        n_hex_accum = hex_next;
                        if (r_hex_count != 2'd3) begin
                            n_hex_count = 2'(r_hex_count + 2'd1);
                        end else begin
                            n_hex_count = 2'd0;
                            if (r_mode == M_HEX1 && hex_next >= SURR_HI_LO &&
                                hex_next <= SURR_HI_HI) begin
                                n_high = hex_next[9:0];
                                n_mode = M_WANT_BS;
                            end else if (r_mode == M_HEX1 && hex_next >= SURR_LO_LO &&
                                         hex_next <= SURR_LO_HI) begin
                                o_job_push = 1'b1;
                                o_job.err  = ERR_UNPAIRED_LO;
                                n_mode     = M_IDLE;
                            end else if (r_mode == M_HEX2 && (hex_next < SURR_LO_LO ||
                                         hex_next > SURR_LO_HI)) begin
                                o_job_push = 1'b1;
                                o_job.err  = ERR_BAD_LOW;
                                n_mode     = M_IDLE;
                            end else begin
                                o_job_push     = 1'b1;
                                o_job.is_data  = 1'b1;
                                o_job.bytes    = enc_bytes;
                                o_job.last_idx = enc_last;
                                n_mode         = M_BODY;
                            end
                        end
                    end
                end
                M_WANT_BS: begin
                    if (b == CH_BSL) begin
                        n_mode = M_WANT_U;
                    end else begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_UNPAIRED_HI;
                        n_mode     = M_IDLE;
                    end
                end
                M_WANT_U: begin
                    if (b == CH_U) begin
                        n_mode      = M_HEX2;
                        n_hex_count = 2'd0;
                        n_hex_accum = 16'd0;
                    end else begin
                        o_job_push = 1'b1;
                        o_job.err  = ERR_UNPAIRED_HI;
                        n_mode     = M_IDLE;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end

        if (!i_take) begin
            o_job_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_hex_count <= 2'd0;
            r_hex_accum <= 16'd0;
            r_high      <= 10'd0;
            r_tail      <= 2'd0;
            r_scalar    <= 21'd0;
            r_min       <= 2'd0;
        end else if (i_take) begin
            r_mode      <= n_mode;
            r_hex_count <= n_hex_count;
            r_hex_accum <= n_hex_accum;
            r_high      <= n_high;
            r_tail      <= n_tail;
            r_scalar    <= n_scalar;
            r_min       <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && held_we) begin
            r_held[held_idx] <= b;
        end
    end

endmodule

/* rtl/jsu_fifo.sv */
// Four-entry job queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module jsu_fifo
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (do_push) r_wr_ptr <= 2'(r_wr_ptr + 2'd1);
            if (do_pop)  r_rd_ptr <= 2'(r_rd_ptr + 2'd1);
            if (do_push && !do_pop)      r_count <= 3'(r_count + 3'd1);
            else if (do_pop && !do_push) r_count <= 3'(r_count - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/jsu_back.sv */
// Back end: holds the current job and hands out its results one per transaction.
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_empty,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;
    logic       is_last;
    logic       advance;

    assign is_last = !r_job.is_data || (r_idx == r_job.last_idx);
    // Load the next job when idle or when the final result of this one leaves.
    assign advance   = !r_busy || (i_pop && is_last);
    assign o_job_pop = advance && !i_job_empty;
    assign o_empty   = !r_busy;

    always_comb begin
        o_item.out_byte    = r_job.is_data ? r_job.bytes[r_idx] : 8'd0;
        o_item.byte_valid  = r_job.is_data;
        o_item.string_done = r_job.done;
        o_item.error_code  = r_job.err;
        o_item.last        = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (advance) begin
            r_busy <= !i_job_empty;
            r_idx  <= 2'd0;
        end else if (i_pop) begin
            r_idx <= 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_job <= i_job;
        end
    end

endmodule

/* rtl/json_string_unescaper_top.sv */
// A result passes from its input transaction through a job queue entry and then
// the result register before it is visible.
// Throughput: one input byte per cycle while the queue is not full; results leave
// one per cycle while pop is high, so an input that decodes to several bytes holds the result side until all have left.
// A four-deep job queue decouples the parser from the result side; full rises
// only when it fills. Synchronous reset returns the parser to idle, awaiting the
// opening quote, and empties the queue and the result register.
`timescale 1ns / 1ps

module json_string_unescaper_top
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic job_push;
    t_job job_in;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job job_out;
    logic take;

    assign full = q_full;
    assign take = push && !q_full;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_in_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (job_out),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

/* sim/json_unescape_checker.sv */
// Checker for the JSON string unescaper: predicts decoded output and compares it.
`timescale 1ns / 1ps

module json_unescape_checker
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_in_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);

    t_mode       st_mode;
    logic [1:0]  st_hex_count;
    logic [15:0] st_hex_acc;
    logic [15:0] st_high;
    logic [1:0]  st_tail_left;
    logic [20:0] st_scalar;
    logic [1:0]  st_class;
    logic [7:0]  st_held [3];

    t_out_item decoded_q [$];
    t_out_item want;
    t_out_item got;
    int        mismatch_count = 0;
    int        checked_count = 0;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    task automatic put_out(logic [7:0] b, logic v, logic d, logic [3:0] e, logic l);
        t_out_item r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.string_done = d;
        r.error_code  = e;
        r.last        = l;
        decoded_q.insert(decoded_q.size(), r);
    endtask

    task automatic reject(logic [3:0] code);
        st_mode = M_IDLE;
        put_out(8'h00, 1'b0, 1'b0, code, 1'b1);
    endtask

    task automatic emit_scalar(logic [20:0] p);
        if (p <= 21'h7F) begin
            put_out(p[7:0], 1'b1, 1'b0, ERR_OK, 1'b1);
        end else if (p <= 21'h7FF) begin
            put_out({3'b110, p[10:6]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[5:0]}, 1'b1, 1'b0, ERR_OK, 1'b1);
        end else if (p <= 21'hFFFF) begin
            put_out({4'b1110, p[15:12]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[11:6]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[5:0]}, 1'b1, 1'b0, ERR_OK, 1'b1);
        end else begin
            put_out({5'b11110, p[20:18]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[17:12]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[11:6]}, 1'b1, 1'b0, ERR_OK, 1'b0);
            put_out({2'b10, p[5:0]}, 1'b1, 1'b0, ERR_OK, 1'b1);
        end
    endtask

    task automatic unescape_step(t_in_item it);
        logic [7:0]  b;
        logic [4:0]  nib;
        logic [15:0] hv;
        logic [20:0] p;
        logic [20:0] lo_bound;
        logic [1:0]  k;
        bit          lead_ok;
        int          i;
        b = it.data_byte;
        if (it.end_of_data) begin
            reject(st_mode == M_IDLE ? ERR_NO_QUOTE : ERR_UNTERMINATED);
            return;
        end
        case (st_mode)
            M_IDLE: begin
                if (b != CH_QUOTE) reject(ERR_NO_QUOTE);
                else st_mode = M_BODY;
            end
            M_BODY: begin
                lead_ok = 1'b1;
                if (b == CH_QUOTE) begin
                    st_mode = M_IDLE;
                    put_out(8'h00, 1'b0, 1'b1, ERR_OK, 1'b1);
                end else if (b < 8'h20) begin
                    reject(ERR_CONTROL);
                end else if (b == CH_BSL) begin
                    st_mode = M_ESC;
                end else if (b < 8'h80) begin
                    put_out(b, 1'b1, 1'b0, ERR_OK, 1'b1);
                end else begin
                    if (b >= 8'hC2 && b <= 8'hDF) begin
                        st_class  = 2'd1;
                        st_scalar = {16'd0, b[4:0]};
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        st_class  = 2'd2;
                        st_scalar = {17'd0, b[3:0]};
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        st_class  = 2'd3;
                        st_scalar = {18'd0, b[2:0]};
                    end else begin
                        lead_ok = 1'b0;
                        reject(ERR_LEAD);
                    end
                    if (lead_ok) begin
                        st_tail_left = st_class;
                        st_held[0]   = b;
                        st_mode      = M_TAIL;
                    end
                end
            end
            M_TAIL: begin
                if (b[7:6] != 2'b10) begin
                    reject(ERR_CONT);
                end else begin
                    st_scalar = {st_scalar[14:0], b[5:0]};
                    if (st_tail_left > 2'd1) begin
                        k = st_class - st_tail_left + 2'd1;
                        if (k < 2'd3) st_held[k] = b;
                        st_tail_left = st_tail_left - 2'd1;
                    end else begin
                        // last byte of the sequence: check range, then release all
                        st_tail_left = 2'd0;
                        p = st_scalar;
                        lo_bound = (st_class == 2'd1) ? 21'h80 :
                                   (st_class == 2'd2) ? 21'h800 : SUPP_BASE;
                        if (p < lo_bound || p > MAX_SCALAR ||
                            (p >= {5'd0, SURR_HI_LO} && p <= {5'd0, SURR_LO_HI})) begin
                            reject(ERR_SCALAR);
                        end else begin
                            st_mode = M_BODY;
                            for (i = 0; i < st_class; i++)
                                put_out(st_held[i], 1'b1, 1'b0, ERR_OK, 1'b0);
                            put_out(b, 1'b1, 1'b0, ERR_OK, 1'b1);
                        end
                    end
                end
            end
            M_ESC: begin
                st_mode = M_BODY;
                case (b)
                    CH_QUOTE: put_out(CH_QUOTE, 1'b1, 1'b0, ERR_OK, 1'b1);
                    CH_BSL:   put_out(CH_BSL, 1'b1, 1'b0, ERR_OK, 1'b1);
                    "/":      put_out("/", 1'b1, 1'b0, ERR_OK, 1'b1);
                    "b":      put_out(8'h08, 1'b1, 1'b0, ERR_OK, 1'b1);
                    "f":      put_out(8'h0C, 1'b1, 1'b0, ERR_OK, 1'b1);
                    "n":      put_out(8'h0A, 1'b1, 1'b0, ERR_OK, 1'b1);
                    "r":      put_out(8'h0D, 1'b1, 1'b0, ERR_OK, 1'b1);
                    "t":      put_out(8'h09, 1'b1, 1'b0, ERR_OK, 1'b1);
                    CH_U: begin
                        st_mode      = M_HEX1;
                        st_hex_count = 2'd0;
                        st_hex_acc   = 16'd0;
                    end
                    default:  reject(ERR_ESCAPE);
                endcase
            end
            M_HEX1, M_HEX2: begin
                nib = hex_nibble(b);
                if (nib[4]) begin
                    reject(ERR_HEX);
                end else begin
                    st_hex_acc = {st_hex_acc[11:0], nib[3:0]};
                    if (st_hex_count < 2'd3) begin
                        st_hex_count = st_hex_count + 2'd1;
                    end else begin
                        st_hex_count = 2'd0;
                        hv = st_hex_acc;
                        if (st_mode == M_HEX1) begin
                            if (hv >= SURR_HI_LO && hv <= SURR_HI_HI) begin
                                st_high = hv;
                                st_mode = M_WANT_BS;
                            end else if (hv >= SURR_LO_LO && hv <= SURR_LO_HI) begin
                                reject(ERR_UNPAIRED_LO);
                            end else begin
                                st_mode = M_BODY;
                                emit_scalar({5'd0, hv});
                            end
                        end else if (hv < SURR_LO_LO || hv > SURR_LO_HI) begin
                            reject(ERR_BAD_LOW);
                        end else begin
                            // both halves carry their payload in the low ten bits
                            st_mode = M_BODY;
                            emit_scalar(SUPP_BASE + {1'b0, st_high[9:0], hv[9:0]});
                        end
                    end
                end
            end
            M_WANT_BS: begin
                if (b != CH_BSL) reject(ERR_UNPAIRED_HI);
                else st_mode = M_WANT_U;
            end
            M_WANT_U: begin
                if (b != CH_U) begin
                    reject(ERR_UNPAIRED_HI);
                end else begin
                    st_mode      = M_HEX2;
                    st_hex_count = 2'd0;
                    st_hex_acc   = 16'd0;
                end
            end
            default: st_mode = M_IDLE;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            st_mode      = M_IDLE;
            st_hex_count = 2'd0;
            st_hex_acc   = 16'd0;
            st_high      = 16'd0;
            st_tail_left = 2'd0;
            st_scalar    = 21'd0;
            st_class     = 2'd0;
            st_held[0]   = 8'd0;
            st_held[1]   = 8'd0;
            st_held[2]   = 8'd0;
            decoded_q.delete();
        end else begin
            if (i_push && !i_full) unescape_step(i_in_item);
            if (i_pop && !i_empty) begin
                got = i_out_item;
                if (decoded_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual byte=%02h valid=%0b",
                             $time, got.out_byte, got.byte_valid,
                             " done=%0b err=%0d last=%0b",
                             got.string_done, got.error_code, got.last);
                end else begin
                    want = decoded_q.pop_front();
                    checked_count++;
                    if (got.out_byte !== want.out_byte ||
                        got.byte_valid !== want.byte_valid ||
                        got.string_done !== want.string_done ||
                        got.error_code !== want.error_code ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: mismatch, expected byte=%02h valid=%0b done=%0b",
                                 $time, want.out_byte, want.byte_valid, want.string_done,
                                 " err=%0d last=%0b", want.error_code, want.last);
                        $display("%0t:           actual byte=%02h valid=%0b done=%0b",
                                 $time, got.out_byte, got.byte_valid, got.string_done,
                                 " err=%0d last=%0b", got.error_code, got.last);
                    end
                end
            end
        end
        o_pending <= decoded_q.size();
        o_errors  <= mismatch_count;
        o_checked <= checked_count;
    end

endmodule

/* sim/json_string_unescaper_top_test.sv */
// Testbench top for the JSON string unescaper: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module json_string_unescaper_top_test;
    import jsu_pkg::*;

    localparam int ITEM_TARGET = 310;
    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item out_item;

    int errors;
    int pending;
    int checked;

    t_in_item text_q [$];
    int       sent_count = 0;
    int       string_count = 0;
    int       burst_left = 0;

    json_string_unescaper_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    json_unescape_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_item  (in_item),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out_item (out_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic add_byte(logic [7:0] b);
        t_in_item it;
        it.data_byte   = b;
        it.end_of_data = 1'b0;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic add_eod();
        t_in_item it;
        it.data_byte   = 8'($urandom_range(0, 255));
        it.end_of_data = 1'b1;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic add_hex4(logic [15:0] v);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endtask

    // Drain the text queue in bursts; push stays high across back-to-back transactions.
    task automatic send_text();
        int gap;
        while (text_q.size() > 0) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            push    <= 1'b1;
            in_item <= text_q.pop_front();
            @(posedge clk);
            while (full) @(posedge clk);
            burst_left--;
            sent_count++;
        end
    endtask

    // Hold off the sender until every predicted result has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : rx_stall
        int phase;
        int span;
        wait (rst_n === 1'b1);
        forever begin
            phase = $urandom_range(0, 3);
            span  = $urandom_range(4, 40);
            repeat (span) begin
                @(posedge clk);
                case (phase)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 5) == 0);
                    default: pop <= 1'b0;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  b;
        logic [15:0] v;
        logic [15:0] hi;
        int          cls;
        int          n;
        int          ntok;
        int          t;
        bit          faulted;
        bit          paused_mid;

        paused_mid = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle garbage, idle end, printable extremes, escaped NUL,
        // control byte, largest raw scalar, bad lead, unterminated string.
        add_byte("x");
        add_eod();
        add_byte(CH_QUOTE);
        add_byte(8'h20);
        add_byte(8'h7F);
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_hex4(16'h0000);
        add_byte(8'h1F);
        add_byte(CH_QUOTE);
        add_byte(8'hF4);
        add_byte(8'h8F);
        add_byte(8'hBF);
        add_byte(8'hBF);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte(8'hFF);
        add_byte(CH_QUOTE);
        add_eod();
        send_text();
        wait_drained();

        while (sent_count < ITEM_TARGET) begin
            if (!paused_mid && sent_count >= ITEM_TARGET / 2) begin
                paused_mid = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 19) == 0) begin
                // noise, which may land inside a string left open
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) add_eod();
                    else add_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                string_count++;
                add_byte(CH_QUOTE);
                ntok    = $urandom_range(1, 8);
                faulted = 1'b0;
                for (t = 0; t < ntok && !faulted; t++) begin
                    if ($urandom_range(0, 99) < 10) begin
                        faulted = 1'b1;
                        case ($urandom_range(0, 9))
                            0: add_byte(8'($urandom_range(0, 8'h1F)));
                            1: begin
                                do b = 8'($urandom_range(0, 255));
                                while (b == CH_QUOTE || b == CH_BSL || b == "/" ||
                                       b == "b" || b == "f" || b == "n" || b == "r" ||
                                       b == "t" || b == CH_U);
                                add_byte(CH_BSL);
                                add_byte(b);
                            end
                            2: begin
                                if ($urandom_range(0, 1)) begin
                                    add_byte(CH_BSL);
                                    add_byte(CH_U);
                                    add_hex4(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
                                end
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                repeat ($urandom_range(0, 3))
                                    add_byte(hex_char(4'($urandom_range(0, 15))));
                                do b = 8'($urandom_range(0, 255));
                                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                                       (b >= "A" && b <= "F"));
                                add_byte(b);
                            end
                            3: begin
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
                                if ($urandom_range(0, 1)) begin
                                    do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
                                end else begin
                                    add_byte(CH_BSL);
                                    do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                                end
                                add_byte(b);
                            end
                            4: begin
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                v = 16'($urandom_range(0, 16'hFFFF));
                                if (v >= SURR_LO_LO && v <= SURR_LO_HI) v ^= 16'h4000;
                                add_hex4(v);
                            end
                            5: begin
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(16'($urandom_range(SURR_LO_LO, SURR_LO_HI)));
                            end
                            6: begin
                                if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h80, 8'hC1)));
                                else add_byte(8'($urandom_range(8'hF5, 8'hFF)));
                            end
                            7: begin
                                // lead without special second-byte limits
                                cls = $urandom_range(1, 3);
                                case (cls)
                                    1:       add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                                    2:       add_byte(8'($urandom_range(8'hE1, 8'hEC)));
                                    default: add_byte(8'($urandom_range(8'hF1, 8'hF3)));
                                endcase
                                repeat ($urandom_range(0, cls - 1)) add_byte(rand_cont());
                                do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
                                add_byte(b);
                            end
                            8: begin
                                // overlong, encoded surrogate, or above the last scalar
                                case ($urandom_range(0, 3))
                                    0: begin
                                        add_byte(8'hE0);
                                        add_byte(8'($urandom_range(8'h80, 8'h9F)));
                                    end
                                    1: begin
                                        add_byte(8'hED);
                                        add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                                    end
                                    2: begin
                                        add_byte(8'hF0);
                                        add_byte(8'($urandom_range(8'h80, 8'h8F)));
                                        add_byte(rand_cont());
                                    end
                                    default: begin
                                        add_byte(8'hF4);
                                        add_byte(8'($urandom_range(8'h90, 8'hBF)));
                                        add_byte(rand_cont());
                                    end
                                endcase
                                add_byte(rand_cont());
                            end
                            default: begin
                                // end of data partway through something
                                case ($urandom_range(0, 5))
                                    0: ;
                                    1: add_byte(CH_BSL);
                                    2: begin
                                        add_byte(CH_BSL);
                                        add_byte(CH_U);
                                        repeat ($urandom_range(0, 3))
                                            add_byte(hex_char(4'($urandom_range(0, 15))));
                                    end
                                    3: begin
                                        add_byte(CH_BSL);
                                        add_byte(CH_U);
                                        add_hex4(16'hD83D);
                                        if ($urandom_range(0, 1)) add_byte(CH_BSL);
                                    end
                                    4: begin
                                        add_byte(CH_BSL);
                                        add_byte(CH_U);
                                        add_hex4(16'hDBFF);
                                        add_byte(CH_BSL);
                                        add_byte(CH_U);
                                        repeat ($urandom_range(0, 3))
                                            add_byte(hex_char(4'($urandom_range(0, 15))));
                                    end
                                    default: begin
                                        cls = $urandom_range(1, 3);
                                        add_byte(cls == 1 ? 8'hC2 : cls == 2 ? 8'hE1 : 8'hF1);
                                        repeat ($urandom_range(0, cls - 1)) add_byte(rand_cont());
                                    end
                                endcase
                                add_eod();
                            end
                        endcase
                    end else begin
                        case ($urandom_range(0, 6))
                            0, 1: begin
                                do b = 8'($urandom_range(8'h20, 8'h7F));
                                while (b == CH_QUOTE || b == CH_BSL);
                                add_byte(b);
                            end
                            2: begin
                                add_byte(CH_BSL);
                                case ($urandom_range(0, 7))
                                    0:       add_byte(CH_QUOTE);
                                    1:       add_byte(CH_BSL);
                                    2:       add_byte("/");
                                    3:       add_byte("b");
                                    4:       add_byte("f");
                                    5:       add_byte("n");
                                    6:       add_byte("r");
                                    default: add_byte("t");
                                endcase
                            end
                            3: begin
                                case ($urandom_range(0, 11))
                                    0:       v = 16'h0000;
                                    1:       v = 16'h007F;
                                    2:       v = 16'h0080;
                                    3:       v = 16'h07FF;
                                    4:       v = 16'h0800;
                                    5:       v = 16'hFFFF;
                                    6:       v = 16'hD7FF;
                                    7:       v = 16'hE000;
                                    default: begin
                                        v = 16'($urandom_range(0, 16'hFFFF));
                                        if (v >= SURR_HI_LO && v <= SURR_LO_HI) v ^= 16'h4000;
                                    end
                                endcase
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(v);
                            end
                            4: begin
                                case ($urandom_range(0, 3))
                                    0:       hi = SURR_HI_LO;
                                    1:       hi = SURR_HI_HI;
                                    default: hi = 16'($urandom_range(SURR_HI_LO, SURR_HI_HI));
                                endcase
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(hi);
                                add_byte(CH_BSL);
                                add_byte(CH_U);
                                add_hex4(16'($urandom_range(SURR_LO_LO, SURR_LO_HI)));
                            end
                            default: begin
                                // well-formed raw UTF-8, 2 to 4 bytes
                                cls = $urandom_range(1, 3);
                                if (cls == 1) begin
                                    add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                                    add_byte(rand_cont());
                                end else if (cls == 2) begin
                                    b = 8'($urandom_range(8'hE0, 8'hEF));
                                    add_byte(b);
                                    if (b == 8'hE0) add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                                    else if (b == 8'hED) add_byte(8'($urandom_range(8'h80, 8'h9F)));
                                    else add_byte(rand_cont());
                                    add_byte(rand_cont());
                                end else begin
                                    b = 8'($urandom_range(8'hF0, 8'hF4));
                                    add_byte(b);
                                    if (b == 8'hF0) add_byte(8'($urandom_range(8'h90, 8'hBF)));
                                    else if (b == 8'hF4) add_byte(8'($urandom_range(8'h80, 8'h8F)));
                                    else add_byte(rand_cont());
                                    add_byte(rand_cont());
                                    add_byte(rand_cont());
                                end
                            end
                        endcase
                    end
                end
                if (!faulted) begin
                    n = $urandom_range(0, 19);
                    // an open string is left for the next opening quote to close
                    if (n < 17) add_byte(CH_QUOTE);
                    else if (n < 19) add_eod();
                end
            end
            send_text();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d input transactions in %0d random strings plus directed text;",
                 sent_count, string_count);
        $display("checked %0d results over escapes, surrogates, raw UTF-8 and all error codes.",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_top.sv
sim/json_unescape_checker.sv
sim/json_string_unescaper_top_test.sv
